[rtl/core/color_key_halo_alpha_assert.svh]
// assertion macros shared by the checker files
`ifndef COLOR_KEY_HALO_ALPHA_ASSERT_SVH
`define COLOR_KEY_HALO_ALPHA_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define CKHA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ckha check failed");

// next-cycle implication, sampled on clk, off during rst
`define CKHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ckha check failed");

`endif

[rtl/core/ckha_pkg.sv]
// ----------------------------------------------------------------------------
// ckha_pkg
// Shared widths and codes of the color key / halo alpha block.
// ----------------------------------------------------------------------------
package ckha_pkg;

  localparam int CMD_W     = 2;
  localparam int COORD_W   = 9;
  localparam int PIXEL_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALO_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALO_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_INDEX  = 3'd6;

endpackage

[rtl/core/ckha_if.sv]
// ----------------------------------------------------------------------------
// ckha_if
// Channel interfaces: pixel commands, results and register writes.
// ----------------------------------------------------------------------------
interface ckha_pix_if;
  logic                          valid;
  logic                          ready;
  logic [ckha_pkg::CMD_W-1:0]    cmd;
  logic [ckha_pkg::COORD_W-1:0]  col;
  logic [ckha_pkg::COORD_W-1:0]  row;
  logic [ckha_pkg::PIXEL_W-1:0]  pixel_in;

  modport source (output valid, cmd, col, row, pixel_in, input ready);
  modport sink (input valid, cmd, col, row, pixel_in, output ready);
endinterface

interface ckha_res_if;
  logic                          valid;
  logic                          ready;
  logic [ckha_pkg::PIXEL_W-1:0]  pixel_out;
  logic                          done_res;

  modport source (output valid, pixel_out, done_res, input ready);
  modport sink (input valid, pixel_out, done_res, output ready);
endinterface

interface ckha_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ckha_pkg::CFG_IDX_W-1:0] index;
  logic [ckha_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/color_key_halo_alpha.sv]
// ----------------------------------------------------------------------------
// color_key_halo_alpha
// Frame store with color-key alpha clearing and a distance-weighted alpha
// halo around non-key pixels. A pixel write is stored at acceptance and the
// next transaction may follow at once unless a result is stalled; a read
// passes through the read-wait state and returns the stored pixel, or zero
// outside the store. A run first divides the image height by the frame count
// on a bit-serial divider (CW = coordinate width, 10 at the default size),
// then visits every band pixel on the key pass. Unless the halo width is zero,
// the halo pass visits every band pixel and, for a non-key pixel, each pixel
// of its window, skipping those whose alpha is already 255 and otherwise
// dividing the gain on the same divider. Every step shares the single-port
// frame store with its registered read. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module color_key_halo_alpha #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_HALO   = 15
) (
  input  logic        clk,
  input  logic        rst,
  ckha_cfg_if.sink    cfg,
  ckha_pix_if.sink    pix,
  ckha_res_if.source  res
);

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW0     = $clog2(MAX_DIM + MAX_HALO + 2);
  localparam int CW      = (CW0 > 10) ? CW0 : 10;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW0     = $clog2(DEPTH);
  localparam int AW      = (AW0 > 0) ? AW0 : 1;
  localparam int CNTW    = $clog2(CW + 1);
  localparam int PW      = 6 + CW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_WAIT, ST_FH_DIV, ST_BAND, ST_P1_LOOP, ST_P1_MOD, ST_P2_START,
    ST_O_LOOP, ST_O_CHK, ST_T_LOOP, ST_T_CHK, ST_T_DIV, ST_T_WR, ST_DONE
  } state_t;

  // configuration registers
  logic [23:0] key_color;
  logic [3:0]  halo_width;
  logic [9:0]  halo_gain;
  logic [9:0]  image_width;
  logic [9:0]  image_height;
  logic [6:0]  frame_count;
  logic [5:0]  frame_index;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_color    <= '0;
      halo_width   <= '0;
      halo_gain    <= '0;
      image_width  <= 10'd320;
      image_height <= 10'd200;
      frame_count  <= 7'd1;
      frame_index  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ckha_pkg::REG_KEY_COLOR:    key_color    <= cfg.data;
        ckha_pkg::REG_HALO_WIDTH:   halo_width   <= cfg.data[3:0];
        ckha_pkg::REG_HALO_GAIN:    halo_gain    <= cfg.data[9:0];
        ckha_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data[9:0];
        ckha_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data[9:0];
        ckha_pkg::REG_FRAME_COUNT:  frame_count  <= cfg.data[6:0];
        ckha_pkg::REG_FRAME_INDEX:  frame_index  <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [CW-1:0] w_eff;
  logic [CW-1:0] h_eff;
  logic [6:0]    fc_eff;
  logic [3:0]    s_eff;

  assign w_eff  = (CW'(image_width) < CW'(MAX_WIDTH)) ? CW'(image_width) : CW'(MAX_WIDTH);
  assign h_eff  = (CW'(image_height) < CW'(MAX_HEIGHT)) ? CW'(image_height)
                                                         : CW'(MAX_HEIGHT);
  assign fc_eff = (frame_count == 7'd0) ? 7'd1 : frame_count;
  assign s_eff  = (32'(halo_width) < MAX_HALO) ? halo_width : 4'(MAX_HALO);

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
    addr_of = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  // state
  state_t                     state;
  logic                       out_valid;
  logic [ckha_pkg::PIXEL_W-1:0] out_pixel;
  logic                       out_done;
  logic                       rd_inside;
  logic [CW-1:0]              fh;
  logic [CW-1:0]              top;
  logic [CW-1:0]              bottom;
  logic [CW-1:0]              x;
  logic [CW-1:0]              y;
  logic [CW-1:0]              tx;
  logic [CW-1:0]              ty;
  logic [CW-1:0]              xe;
  logic [CW-1:0]              ys;
  logic [CW-1:0]              ye;
  logic [ckha_pkg::PIXEL_W-1:0] t_px;

  // bit-serial restoring divider
  logic [6:0]      dv_rem;
  logic [CW-1:0]   dv_num;
  logic [6:0]      dv_den;
  logic [CNTW-1:0] dv_cnt;
  logic [7:0]      dv_sh;
  logic            dv_ge;
  logic [6:0]      dv_rem_next;
  logic [CW-1:0]   dv_num_next;
  logic            dv_last;

  assign dv_sh       = {dv_rem, dv_num[CW-1]};
  assign dv_ge       = dv_sh >= {1'b0, dv_den};
  assign dv_rem_next = dv_ge ? 7'(dv_sh - {1'b0, dv_den}) : dv_sh[6:0];
  assign dv_num_next = {dv_num[CW-2:0], dv_ge};
  assign dv_last     = dv_cnt == CNTW'(CW - 1);

  // frame store
  logic [ckha_pkg::PIXEL_W-1:0] mem [DEPTH];
  logic [ckha_pkg::PIXEL_W-1:0] mem_q;
  logic [AW-1:0]                mem_addr;
  logic                         mem_we;
  logic [ckha_pkg::PIXEL_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q <= mem[mem_addr];
  end

  logic          pix_acc;
  logic          host_inside;
  logic          q_is_key;
  logic [CW:0]   na_sum;
  logic [7:0]    na;

  assign pix.ready   = (state == ST_IDLE) && (!out_valid || res.ready);
  assign pix_acc     = pix.valid && pix.ready;
  assign host_inside = (32'(pix.col) < MAX_WIDTH) && (32'(pix.row) < MAX_HEIGHT);
  assign q_is_key    = mem_q[31:8] == key_color;
  assign na_sum      = (CW + 1)'(t_px[7:0]) + (CW + 1)'(dv_num);
  assign na          = (na_sum > (CW + 1)'(255)) ? 8'hFF : na_sum[7:0];

  assign res.valid     = out_valid;
  assign res.pixel_out = out_pixel;
  assign res.done_res  = out_done;

  always_comb begin
    mem_we = 1'b0;
    mem_wd = pix.pixel_in;
    case (state)
      ST_IDLE: begin
        mem_addr = addr_of(CW'(pix.col), CW'(pix.row));
        mem_we   = pix_acc && (pix.cmd == ckha_pkg::CMD_WRITE) && host_inside;
      end
      ST_P1_LOOP, ST_O_LOOP: mem_addr = addr_of(x, y);
      ST_P1_MOD: begin
        mem_addr = addr_of(x, y);
        mem_we   = q_is_key;
        mem_wd   = {mem_q[31:8], 8'h00};
      end
      ST_T_LOOP: mem_addr = addr_of(tx, ty);
      ST_T_WR: begin
        mem_addr = addr_of(tx, ty);
        mem_we   = 1'b1;
        mem_wd   = {t_px[31:8], na};
      end
      default: mem_addr = addr_of(x, y);
    endcase
  end

  // band bounds
  logic [PW-1:0] top_full;
  logic [CW-1:0] top_c;
  logic [CW:0]   bot_sum;
  logic [CW-1:0] bot_c;

  assign top_full = PW'(frame_index) * PW'(fh);
  assign top_c    = (top_full > PW'(h_eff)) ? h_eff : CW'(top_full);
  assign bot_sum  = (CW + 1)'(top_c) + (CW + 1)'(fh);
  assign bot_c    = (bot_sum > (CW + 1)'(h_eff)) ? h_eff : CW'(bot_sum);

  // halo window of the current origin
  logic [CW-1:0] s_c;
  logic [CW-1:0] ys0;
  logic [CW-1:0] xe_sum;
  logic [CW-1:0] ye_sum;
  logic [CW-1:0] dx;
  logic [CW-1:0] dy;
  logic [4:0]    div_t;

  assign s_c    = CW'(s_eff);
  assign ys0    = (y >= s_c) ? y - s_c : '0;
  assign xe_sum = x + s_c + CW'(1);
  assign ye_sum = y + s_c + CW'(1);
  assign dx     = (x >= tx) ? x - tx : tx - x;
  assign dy     = (y >= ty) ? y - ty : ty - y;
  assign div_t  = 5'({s_eff, 1'b1}) - 5'(dx) - 5'(dy);

  logic origin_last_x;
  logic t_last_y;
  logic t_last_x;

  assign origin_last_x = (x + CW'(1)) == w_eff;
  assign t_last_y      = (ty + CW'(1)) == ye;
  assign t_last_x      = (tx + CW'(1)) == xe;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pix_acc) begin
            rd_inside <= host_inside;
            case (pix.cmd)
              ckha_pkg::CMD_READ: state <= ST_RD_WAIT;
              ckha_pkg::CMD_RUN: begin
                dv_rem <= '0;
                dv_num <= h_eff;
                dv_den <= fc_eff;
                dv_cnt <= '0;
                state  <= ST_FH_DIV;
              end
              default: ;
            endcase
          end
        end
        ST_RD_WAIT: begin
          out_valid <= 1'b1;
          out_pixel <= rd_inside ? mem_q : '0;
          out_done  <= 1'b0;
          state     <= ST_IDLE;
        end
        ST_FH_DIV: begin
          dv_rem <= dv_rem_next;
          dv_num <= dv_num_next;
          dv_cnt <= dv_cnt + CNTW'(1);
          if (dv_last) begin
            fh    <= dv_num_next;
            state <= ST_BAND;
          end
        end
        ST_BAND: begin
          top    <= top_c;
          bottom <= bot_c;
          x      <= '0;
          y      <= top_c;
          state  <= ST_P1_LOOP;
        end
        ST_P1_LOOP: begin
          if (y >= bottom || w_eff == '0) begin
            state <= ST_P2_START;
          end else begin
            state <= ST_P1_MOD;
          end
        end
        ST_P1_MOD: begin
          if (origin_last_x) begin
            x <= '0;
            y <= y + CW'(1);
          end else begin
            x <= x + CW'(1);
          end
          state <= ST_P1_LOOP;
        end
        ST_P2_START: begin
          x <= '0;
          y <= top;
          state <= (s_eff == 4'd0) ? ST_DONE : ST_O_LOOP;
        end
        ST_O_LOOP: begin
          if (y >= bottom || w_eff == '0) begin
            state <= ST_DONE;
          end else begin
            state <= ST_O_CHK;
          end
        end
        ST_O_CHK: begin
          if (q_is_key) begin
            if (origin_last_x) begin
              x <= '0;
              y <= y + CW'(1);
            end else begin
              x <= x + CW'(1);
            end
            state <= ST_O_LOOP;
          end else begin
            xe    <= (xe_sum < w_eff) ? xe_sum : w_eff;
            ys    <= (ys0 < top) ? top : ys0;
            ye    <= (ye_sum < bottom) ? ye_sum : bottom;
            tx    <= (x >= s_c) ? x - s_c : '0;
            ty    <= (ys0 < top) ? top : ys0;
            state <= ST_T_LOOP;
          end
        end
        ST_T_LOOP: state <= ST_T_CHK;
        ST_T_CHK: begin
          t_px <= mem_q;
          if (mem_q[7:0] == 8'hFF) begin
            // opaque already, step to the next window pixel
            if (t_last_y) begin
              ty <= ys;
              if (t_last_x) begin
                if (origin_last_x) begin
                  x <= '0;
                  y <= y + CW'(1);
                end else begin
                  x <= x + CW'(1);
                end
                state <= ST_O_LOOP;
              end else begin
                tx    <= tx + CW'(1);
                state <= ST_T_LOOP;
              end
            end else begin
              ty    <= ty + CW'(1);
              state <= ST_T_LOOP;
            end
          end else begin
            dv_rem <= '0;
            dv_num <= CW'(halo_gain);
            dv_den <= 7'(div_t);
            dv_cnt <= '0;
            state  <= ST_T_DIV;
          end
        end
        ST_T_DIV: begin
          dv_rem <= dv_rem_next;
          dv_num <= dv_num_next;
          dv_cnt <= dv_cnt + CNTW'(1);
          if (dv_last) begin
            state <= ST_T_WR;
          end
        end
        ST_T_WR: begin
          if (t_last_y) begin
            ty <= ys;
            if (t_last_x) begin
              if (origin_last_x) begin
                x <= '0;
                y <= y + CW'(1);
              end else begin
                x <= x + CW'(1);
              end
              state <= ST_O_LOOP;
            end else begin
              tx    <= tx + CW'(1);
              state <= ST_T_LOOP;
            end
          end else begin
            ty    <= ty + CW'(1);
            state <= ST_T_LOOP;
          end
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          out_pixel <= '0;
          out_done  <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/ckha_check.sv]
// ----------------------------------------------------------------------------
// ckha_check
// Port-level checks of the color key / halo alpha block.
// ----------------------------------------------------------------------------
`include "color_key_halo_alpha_assert.svh"

module ckha_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       pix_valid,
  input logic                       pix_ready,
  input logic [ckha_pkg::CMD_W-1:0] pix_cmd,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic                       res_done_res
);

  // a stalled result stays offered
  `CKHA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
  // no transaction is taken while a result is stuck
  `CKHA_ASSERT_IMPL(a_no_acc_stall, pix_valid && pix_ready, !(res_valid && !res_ready))
  // a read answers with a pixel, not a done
  `CKHA_ASSERT_IMPL(a_read_lat, pix_valid && pix_ready && pix_cmd == ckha_pkg::CMD_READ, ##2 (res_valid && !res_done_res))

endmodule

bind color_key_halo_alpha ckha_check u_ckha_check (
  .clk          (clk),
  .rst          (rst),
  .pix_valid    (pix.valid),
  .pix_ready    (pix.ready),
  .pix_cmd      (pix.cmd),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_done_res (res.done_res)
);
